@@ hdl/ctp_pkg.sv @@
// Package for the cue timestamp parser: character codes, field widths and
// the record passed from the token parser to the time arithmetic.
// No dependencies.
`default_nettype none

package ctp_pkg;

  // largest number of hours digits that are accumulated
  localparam int unsigned MAX_HOUR_DIGITS = 8;

  // ascii codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_STOP  = 8'h2E;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // digit counter saturates here
  localparam logic [3:0] DIGIT_SAT   = 4'd15;
  localparam logic [3:0] SMALL_LIMIT = 4'd3;
  localparam logic [3:0] HOUR_LIMIT  = 4'(MAX_HOUR_DIGITS);

  // accumulator holds the hours or a three-digit fraction, whichever is wider
  localparam int unsigned HOUR_CLOG = $clog2(64'(10) ** MAX_HOUR_DIGITS);
  localparam int unsigned HOUR_W    = (HOUR_CLOG > 10) ? HOUR_CLOG : 10;
  localparam int unsigned MIN_W     = 7;
  localparam int unsigned FRAC_W    = 10;

  // time arithmetic
  localparam int unsigned TIME_W  = 49;
  localparam int unsigned HMUL_W  = 22;
  localparam int unsigned PROD_W  = HOUR_W + HMUL_W;
  localparam int unsigned REST_W  = 23;
  localparam int unsigned SUM_W   = (PROD_W + 1 > TIME_W + 1) ? PROD_W + 1 : TIME_W + 1;
  localparam logic [HMUL_W-1:0] MS_PER_HOUR = HMUL_W'(3600000);
  localparam logic [15:0]       MS_PER_MIN  = 16'd60000;
  localparam logic [9:0]        MS_PER_SEC  = 10'd1000;
  localparam logic [MIN_W-1:0]  MAX_MINSEC  = 7'd59;

  // stream widths
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = ((TIME_W + 7) / 8) * 8;

  // parsed token handed to the time arithmetic
  typedef struct packed {
    logic              ok;
    logic [HOUR_W-1:0] hours;
    logic [MIN_W-1:0]  minutes;
    logic [MIN_W-1:0]  seconds;
    logic [FRAC_W-1:0] millis;
  } ctp_fields_t;

endpackage

`default_nettype wire

@@ hdl/ctp_parser.sv @@
// Token parser of the cue timestamp parser: consumes one byte per cycle while
// its output is free, registering the fields when a token's last byte arrives.
// Depends on ctp_pkg.
`default_nettype none

module ctp_parser import ctp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        byte_valid_i,
  output      logic        byte_ready_o,
  input  wire logic [7:0]  byte_i,
  input  wire logic        last_i,
  output      logic        tok_valid_o,
  input  wire logic        tok_ready_i,
  output      ctp_fields_t tok_o
);

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_SECOND,
    PH_THIRD,
    PH_FRAC,
    PH_DONE
  } phase_e;

  typedef struct packed {
    phase_e            phase;
    logic [HOUR_W-1:0] accum;
    logic [3:0]        digits;
    logic [HOUR_W-1:0] first;
    logic [MIN_W-1:0]  second;
    logic [MIN_W-1:0]  third;
    logic [FRAC_W-1:0] frac;
    logic              hours;
    logic              failed;
  } parse_t;

  localparam parse_t PARSE_RESET = '{
    phase:  PH_FIRST,
    accum:  '0,
    digits: '0,
    first:  '0,
    second: '0,
    third:  '0,
    frac:   '0,
    hours:  1'b0,
    failed: 1'b0
  };

  // one parse step on one character
  function automatic parse_t take_byte(parse_t st, logic [7:0] c);
    parse_t     n;
    logic [3:0] limit;
    logic       hp;
    n     = st;
    limit = (st.phase == PH_FIRST) ? HOUR_LIMIT : SMALL_LIMIT;
    hp    = (st.digits != 4'd2) || (st.accum > HOUR_W'(59));
    if (!st.failed && st.phase != PH_DONE) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        if (st.digits != DIGIT_SAT) begin
          n.digits = st.digits + 4'd1;
        end
        if (n.digits <= limit) begin
          n.accum = HOUR_W'(st.accum * HOUR_W'(10)) + HOUR_W'(c[3:0]);
        end
      end else if (st.digits == 4'd0) begin
        n.failed = 1'b1;
      end else begin
        case (st.phase)
          PH_FIRST: begin
            n.first = st.accum;
            n.hours = hp;
            if ((hp && st.digits > HOUR_LIMIT) || c != CH_COLON) begin
              n.failed = 1'b1;
            end else begin
              n.phase  = PH_SECOND;
              n.accum  = '0;
              n.digits = '0;
            end
          end
          PH_SECOND: begin
            if (st.digits != 4'd2) begin
              n.failed = 1'b1;
            end else if (st.hours || c == CH_COLON) begin
              n.second = st.accum[MIN_W-1:0];
              if (c != CH_COLON) begin
                n.failed = 1'b1;
              end else begin
                n.phase  = PH_THIRD;
                n.accum  = '0;
                n.digits = '0;
              end
            end else if (c != CH_STOP) begin
              n.failed = 1'b1;
            end else begin
              // no hours part: first group was minutes, this one seconds
              n.third  = st.accum[MIN_W-1:0];
              n.second = st.first[MIN_W-1:0];
              n.first  = '0;
              n.phase  = PH_FRAC;
              n.accum  = '0;
              n.digits = '0;
            end
          end
          PH_THIRD: begin
            if (st.digits != 4'd2 || c != CH_STOP) begin
              n.failed = 1'b1;
            end else begin
              n.third  = st.accum[MIN_W-1:0];
              n.phase  = PH_FRAC;
              n.accum  = '0;
              n.digits = '0;
            end
          end
          default: begin
            if (st.digits != 4'd3) begin
              n.failed = 1'b1;
            end else begin
              n.frac   = st.accum[FRAC_W-1:0];
              n.phase  = PH_DONE;
              n.accum  = '0;
              n.digits = '0;
            end
          end
        endcase
      end
    end
    return n;
  endfunction

  parse_t      state_q, state_d;
  parse_t      step_byte, step_end;
  logic        tok_valid_q, tok_valid_d;
  ctp_fields_t tok_q, tok_d;
  logic        take;

  assign byte_ready_o = !tok_valid_q || tok_ready_i;
  assign take         = byte_valid_i && byte_ready_o;

  // the end of a token acts as one more terminating character
  assign step_byte = take_byte(state_q, byte_i);
  assign step_end  = take_byte(step_byte, CH_NUL);

  // next state and token record
  always_comb begin
    state_d     = state_q;
    tok_valid_d = tok_valid_q && !tok_ready_i;
    tok_d       = tok_q;
    if (take) begin
      if (last_i) begin
        state_d       = PARSE_RESET;
        tok_valid_d   = 1'b1;
        tok_d.ok      = !step_end.failed && step_end.phase == PH_DONE &&
                        step_end.second <= MAX_MINSEC && step_end.third <= MAX_MINSEC;
        tok_d.hours   = step_end.first;
        tok_d.minutes = step_end.second;
        tok_d.seconds = step_end.third;
        tok_d.millis  = step_end.frac;
      end else begin
        state_d = step_byte;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= PARSE_RESET;
      tok_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tok_valid_q <= tok_valid_d;
    end
  end

  // token payload
  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_o       = tok_q;

endmodule

`default_nettype wire

@@ hdl/ctp_time.sv @@
// Time arithmetic of the cue timestamp parser: turns parsed hours, minutes,
// seconds and milliseconds into total milliseconds over two register stages.
// Depends on ctp_pkg.
`default_nettype none

module ctp_time import ctp_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              tok_valid_i,
  output      logic              tok_ready_o,
  input  wire ctp_fields_t       tok_i,
  output      logic              res_valid_o,
  input  wire logic              res_ready_i,
  output      logic              res_ok_o,
  output      logic [TIME_W-1:0] res_time_o
);

  logic              prod_valid_q;
  logic              prod_ok_q;
  logic [PROD_W-1:0] prod_hour_q;
  logic [REST_W-1:0] prod_rest_q;
  logic              res_valid_q;
  logic              res_ok_q;
  logic [TIME_W-1:0] res_time_q;
  logic              res_space;
  logic              prod_space;
  logic [SUM_W-1:0]  sum;
  logic [REST_W-1:0] rest;

  assign res_space   = !res_valid_q || res_ready_i;
  assign prod_space  = !prod_valid_q || res_space;
  assign tok_ready_o = prod_space;

  // minutes, seconds and milliseconds part
  assign rest = REST_W'(tok_i.minutes) * REST_W'(MS_PER_MIN)
              + REST_W'(tok_i.seconds) * REST_W'(MS_PER_SEC)
              + REST_W'(tok_i.millis);

  // final sum with saturation
  assign sum = SUM_W'(prod_hour_q) + SUM_W'(prod_rest_q);

  // stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (prod_space) begin
        prod_valid_q <= tok_valid_i;
      end
      if (res_space) begin
        res_valid_q <= prod_valid_q;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (prod_space && tok_valid_i) begin
      prod_ok_q   <= tok_i.ok;
      prod_hour_q <= tok_i.hours * MS_PER_HOUR;
      prod_rest_q <= rest;
    end
    if (res_space && prod_valid_q) begin
      res_ok_q <= prod_ok_q;
      if (!prod_ok_q) begin
        res_time_q <= '0;
      end else if (|sum[SUM_W-1:TIME_W]) begin
        res_time_q <= '1;
      end else begin
        res_time_q <= sum[TIME_W-1:0];
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_ok_o    = res_ok_q;
  assign res_time_o  = res_time_q;

endmodule

`default_nettype wire

@@ hdl/cue_timestamp_parser_unit.sv @@
// Top level of the cue timestamp parser: byte stream in, one timestamp
// result per token out. Depends on ctp_pkg, ctp_parser and ctp_time.
//
// Takes the bytes of a timestamp token ("mm:ss.ttt" or "h...:mm:ss.ttt"),
// one byte per transaction, with tlast on the final byte. For every token
// one result transaction follows: tuser is 1 when the token is well formed
// and tdata carries the time in milliseconds (zero when malformed). A byte
// is taken every cycle while the output is not held off; the result passes
// through the parser register, the hours multiplier register and the sum
// register after the last byte is accepted. A zero byte ends the token early
// and bytes past the fraction's terminator are ignored. No configuration.
`default_nettype none

module cue_timestamp_parser_unit import ctp_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] text_byte
  input  wire logic                  s_axis_tlast,  // last_byte
  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output      logic [OUT_DATA_W-1:0] m_axis_tdata,  // [48:0] time_millis, rest zero
  output      logic                  m_axis_tuser   // valid_res
);

  logic              tok_valid;
  logic              tok_ready;
  ctp_fields_t       tok;
  logic [TIME_W-1:0] res_time;

  // byte parser
  ctp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_ready_o (s_axis_tready),
    .byte_i       (s_axis_tdata),
    .last_i       (s_axis_tlast),
    .tok_valid_o  (tok_valid),
    .tok_ready_i  (tok_ready),
    .tok_o        (tok)
  );

  // millisecond arithmetic
  ctp_time u_time (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_ready_o (tok_ready),
    .tok_i       (tok),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_ok_o    (m_axis_tuser),
    .res_time_o  (res_time)
  );

  assign m_axis_tdata = OUT_DATA_W'(res_time);

endmodule

`default_nettype wire
